// ===== rtl/cwps_pkg.sv =====
// Shared constants, mode codes and the command word type for the circular well pixel summer.
// No dependencies; every other file but cwps_ram imports this package.
`default_nettype none

package cwps_pkg;

    localparam int WELLS       = 96;
    localparam int COORD_BITS  = 12;
    localparam int PIXEL_BITS  = 16;
    localparam int SUM_BITS    = 48;
    localparam int INDEX_BITS  = 7;
    localparam int MODE_BITS   = 2;
    localparam int RADIUS_BITS = 8;

    localparam int WELL_ADDR_BITS = (WELLS > 1) ? $clog2(WELLS) : 1;
    localparam int RSQ_BITS       = 2 * RADIUS_BITS;
    localparam int DIST_BITS      = 2 * COORD_BITS + 1;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(16);

    // item modes
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PIXEL = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd3;

    typedef struct packed {
        logic [MODE_BITS-1:0]      op;
        logic                      in_range;
        logic [WELL_ADDR_BITS-1:0] addr;
        logic [INDEX_BITS-1:0]     well;
        logic [COORD_BITS-1:0]     x;
        logic [COORD_BITS-1:0]     y;
        logic [PIXEL_BITS-1:0]     pixel;
    } cwps_cmd_t;

    function automatic logic [WELL_ADDR_BITS-1:0] to_addr(input logic [INDEX_BITS-1:0] idx);
        logic [15:0] wide;
        wide = 16'(idx);
        return wide[WELL_ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cwps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cwps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cwps_front.sv =====
// Front end: takes input words, decodes mode and well range, queues commands.
// Depends on cwps_pkg.
`default_nettype none

module cwps_front
    import cwps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic [MODE_BITS-1:0]  mode,
    input  wire logic [INDEX_BITS-1:0] well_index,
    input  wire logic [COORD_BITS-1:0] x_coord,
    input  wire logic [COORD_BITS-1:0] y_coord,
    input  wire logic [PIXEL_BITS-1:0] pixel_value,
    output logic                       cmd_valid,
    input  wire logic                  cmd_ready,
    output cwps_cmd_t                  cmd
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cwps_cmd_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    cwps_cmd_t           decoded;
    logic                push, pop;

    always_comb
    begin
        decoded.op       = mode;
        decoded.in_range = (int'(well_index) < WELLS);
        decoded.addr     = to_addr(well_index);
        decoded.well     = well_index;
        decoded.x        = x_coord;
        decoded.y        = y_coord;
        decoded.pixel    = pixel_value;
    end

    assign item_ready = (count_reg < CNT_BITS'(QUEUE_DEPTH));
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = queue_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("command queue over-filled");

endmodule

`default_nettype wire

// ===== rtl/cwps_back.sv =====
// Back end: executes queued commands against the centre and sum RAMs.
// Depends on cwps_pkg and cwps_ram.
`default_nettype none

module cwps_back
    import cwps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [RSQ_BITS-1:0]   radius_sq,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire cwps_cmd_t             cmd,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic [INDEX_BITS-1:0]      read_well,
    output logic [SUM_BITS-1:0]        well_sum
);

    localparam int SWEEP_BITS = $clog2(WELLS + 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SWEEP_BITS-1:0] cnt_reg, cnt_next;
    logic [WELLS-1:0]      centre_valid_reg, centre_valid_next;
    logic [WELLS-1:0]      sum_valid_reg, sum_valid_next;
    cwps_cmd_t             cur_reg, cur_next;
    logic                  rd_svalid_reg, rd_svalid_next;

    // sweep pipeline
    logic                      s1_valid_reg, s1_cvalid_reg, s1_svalid_reg;
    logic [WELL_ADDR_BITS-1:0] s1_addr_reg;
    logic                      s2_valid_reg;
    logic [WELL_ADDR_BITS-1:0] s2_addr_reg;
    logic [2*COORD_BITS-1:0]   sq_x_reg, sq_y_reg;
    logic [SUM_BITS-1:0]       s2_sum_reg;

    logic                      result_valid_reg, result_valid_next;
    logic [INDEX_BITS-1:0]     read_well_reg, read_well_next;
    logic [SUM_BITS-1:0]       well_sum_reg, well_sum_next;

    logic                      take, issue;
    logic [WELL_ADDR_BITS-1:0] sweep_addr;
    logic                      centre_we;
    logic [2*COORD_BITS-1:0]   centre_rdata;
    logic                      sum_re;
    logic [WELL_ADDR_BITS-1:0] sum_raddr;
    logic [SUM_BITS-1:0]       sum_rdata;
    logic                      hit;
    logic [SUM_BITS-1:0]       sum_new;

    logic [COORD_BITS-1:0]     cx, cy, dx, dy;
    logic [DIST_BITS-1:0]      dist_sq;
    logic [SUM_BITS:0]         sum_wide;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign take       = cmd_valid && cmd_ready;
    assign issue      = (state_reg == ST_SWEEP) && (cnt_reg < SWEEP_BITS'(WELLS));
    assign sweep_addr = cnt_reg[WELL_ADDR_BITS-1:0];
    assign centre_we  = take && (cmd.op == MODE_LOAD) && cmd.in_range;
    assign sum_raddr  = (state_reg == ST_SWEEP) ? sweep_addr : cmd.addr;
    assign sum_re     = issue || (take && (cmd.op == MODE_READ) && cmd.in_range);

    cwps_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (WELLS)
    ) u_centre_ram (
        .clk     (clk),
        .wr_en   (centre_we),
        .wr_addr (cmd.addr),
        .wr_data ({cmd.x, cmd.y}),
        .rd_en   (issue),
        .rd_addr (sweep_addr),
        .rd_data (centre_rdata)
    );

    cwps_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (WELLS)
    ) u_sum_ram (
        .clk     (clk),
        .wr_en   (hit),
        .wr_addr (s2_addr_reg),
        .wr_data (sum_new),
        .rd_en   (sum_re),
        .rd_addr (sum_raddr),
        .rd_data (sum_rdata)
    );

    // stage 1: distance per axis and its square
    always_comb
    begin
        cx = s1_cvalid_reg ? centre_rdata[2*COORD_BITS-1:COORD_BITS] : '0;
        cy = s1_cvalid_reg ? centre_rdata[COORD_BITS-1:0] : '0;
        dx = (cur_reg.x >= cx) ? (cur_reg.x - cx) : (cx - cur_reg.x);
        dy = (cur_reg.y >= cy) ? (cur_reg.y - cy) : (cy - cur_reg.y);
    end

    // stage 2: disk test and saturating accumulate
    always_comb
    begin
        dist_sq  = DIST_BITS'(sq_x_reg) + DIST_BITS'(sq_y_reg);
        hit      = s2_valid_reg && (dist_sq < DIST_BITS'(radius_sq));
        sum_wide = (SUM_BITS + 1)'(s2_sum_reg) + (SUM_BITS + 1)'(cur_reg.pixel);
        sum_new  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        centre_valid_next = centre_valid_reg;
        sum_valid_next    = sum_valid_reg;
        cur_next          = cur_reg;
        rd_svalid_next    = rd_svalid_reg;
        result_valid_next = result_valid_reg;
        read_well_next    = read_well_reg;
        well_sum_next     = well_sum_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (hit)
        begin
            sum_valid_next[s2_addr_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cur_next = cmd;
                    unique case (cmd.op)
                        MODE_CLEAR:
                        begin
                            sum_valid_next = '0;
                        end
                        MODE_LOAD:
                        begin
                            if (cmd.in_range)
                            begin
                                centre_valid_next[cmd.addr] = 1'b1;
                            end
                        end
                        MODE_PIXEL:
                        begin
                            state_next = ST_SWEEP;
                            cnt_next   = '0;
                        end
                        MODE_READ:
                        begin
                            state_next     = ST_READ;
                            rd_svalid_next = cmd.in_range && sum_valid_reg[cmd.addr];
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SWEEP_BITS'(WELLS + 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    read_well_next    = cur_reg.well;
                    well_sum_next     = rd_svalid_reg ? sum_rdata : '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            centre_valid_reg <= '0;
            sum_valid_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            centre_valid_reg <= centre_valid_next;
            sum_valid_reg    <= sum_valid_next;
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        rd_svalid_reg <= rd_svalid_next;
        read_well_reg <= read_well_next;
        well_sum_reg  <= well_sum_next;
        s1_addr_reg   <= sweep_addr;
        s1_cvalid_reg <= centre_valid_reg[sweep_addr];
        s1_svalid_reg <= sum_valid_reg[sweep_addr];
        s2_addr_reg   <= s1_addr_reg;
        sq_x_reg      <= (2 * COORD_BITS)'(dx) * (2 * COORD_BITS)'(dx);
        sq_y_reg      <= (2 * COORD_BITS)'(dy) * (2 * COORD_BITS)'(dy);
        s2_sum_reg    <= s1_svalid_reg ? sum_rdata : '0;
    end

    assign result_valid = result_valid_reg;
    assign read_well    = read_well_reg;
    assign well_sum     = well_sum_reg;

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result word raised outside a read");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("sweep pipeline busy while idle");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (int'(read_well_reg) >= WELLS)) |-> (well_sum_reg == '0))
        else $error("nonzero sum for a well beyond the table");

endmodule

`default_nettype wire

// ===== rtl/circular_well_pixel_summer.sv =====
// Top level of the circular well pixel summer: radius register, front end, back end.
// Depends on cwps_pkg, cwps_front, cwps_back (and cwps_ram through the back end).
`default_nettype none

// Sums pixel intensity over circular wells. Each input word carries a mode:
// clear zeroes every well sum (centres are kept), load writes one well centre,
// pixel adds pixel_value to every well whose centre lies at squared distance
// below radius squared, read returns one word with read_well and well_sum.
// Sums saturate at all ones; a read of a well beyond the table returns zero and
// a load beyond it is dropped. The radius (reset 16) is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, and the block itself does not enforce this. Radius zero makes pixels
// add nothing. A two-word command queue takes input words while the back end
// works. For a pixel word the back end tests wells one per cycle through a
// shared two-stage distance unit. Clear and load are done as they are taken.
// A read goes through the RAM read, then the output register, and can be held
// by any stall on the result side.
// Centres and sums live in RAMs; per-well valid bits stand for their reset
// and clear values, so no clearing pass is needed.
module circular_well_pixel_summer
    import cwps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [RADIUS_BITS-1:0] cfg_wr_data,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [MODE_BITS-1:0]   mode,
    input  wire logic [INDEX_BITS-1:0]  well_index,
    input  wire logic [COORD_BITS-1:0]  x_coord,
    input  wire logic [COORD_BITS-1:0]  y_coord,
    input  wire logic [PIXEL_BITS-1:0]  pixel_value,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic [INDEX_BITS-1:0]       read_well,
    output logic [SUM_BITS-1:0]         well_sum
);

    // radius kept squared, so the disk test is one add and compare
    logic [RSQ_BITS-1:0] radius_sq_reg, radius_sq_next;
    logic                cmd_valid;
    logic                cmd_ready;
    cwps_cmd_t           cmd;

    assign radius_sq_next = cfg_wr_en ? (RSQ_BITS'(cfg_wr_data) * RSQ_BITS'(cfg_wr_data))
                                      : radius_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= RSQ_BITS'(RADIUS_RESET) * RSQ_BITS'(RADIUS_RESET);
        end
        else
        begin
            radius_sq_reg <= radius_sq_next;
        end
    end

    // front end: accept and decode input words into the command queue
    cwps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .mode        (mode),
        .well_index  (well_index),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .pixel_value (pixel_value),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    // back end: well sweep, table updates, read results
    cwps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius_sq    (radius_sq_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_well    (read_well),
        .well_sum     (well_sum)
    );

endmodule

`default_nettype wire

// ===== tb/cwps_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the circular well pixel summer: watches the config port and both
// word channels, keeps its own centre table, radius and well sums, and checks every read.
// Depends on cwps_pkg only.

module cwps_checker
    import cwps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [RADIUS_BITS-1:0] cfg_wr_data,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  logic [MODE_BITS-1:0]   mode,
    input  logic [INDEX_BITS-1:0]  well_index,
    input  logic [COORD_BITS-1:0]  x_coord,
    input  logic [COORD_BITS-1:0]  y_coord,
    input  logic [PIXEL_BITS-1:0]  pixel_value,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  logic [INDEX_BITS-1:0]  read_well,
    input  logic [SUM_BITS-1:0]    well_sum,
    output int                     outstanding,
    output int                     errors
);

    typedef struct packed {
        logic [INDEX_BITS-1:0] well;
        logic [SUM_BITS-1:0]   sum;
    } read_word_t;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    logic [RADIUS_BITS-1:0] radius_q;
    logic [COORD_BITS-1:0]  centre_x [WELLS];
    logic [COORD_BITS-1:0]  centre_y [WELLS];
    logic [SUM_BITS-1:0]    well_total [WELLS];
    read_word_t             expected_reads [$];
    int                     mismatch_count;

    always @(posedge clk or negedge rst_n)
    begin : track
        int dx;
        int dy;
        int r2;
        logic [SUM_BITS:0] acc;
        read_word_t want;

        if (!rst_n)
        begin
            radius_q = RADIUS_RESET;
            for (int w = 0; w < WELLS; w++)
            begin
                centre_x[w]   = '0;
                centre_y[w]   = '0;
                well_total[w] = '0;
            end
            expected_reads.delete();
            mismatch_count = 0;
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            // result side first: its expectation was fixed when the read was taken
            if (result_valid && result_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected result word: read_well %0d well_sum %0d",
                                 $realtime, read_well, well_sum);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_well !== want.well || well_sum !== want.sum)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: mismatch: read_well exp %0d got %0d, well_sum exp %0d got %0d",
                                     $realtime, want.well, read_well, want.sum, well_sum);
                        mismatch_count++;
                    end
                end
            end

            if (item_valid && item_ready)
            begin
                case (mode)
                    MODE_CLEAR:
                    begin
                        for (int w = 0; w < WELLS; w++)
                            well_total[w] = '0;
                    end
                    MODE_LOAD:
                    begin
                        if (well_index < WELLS)
                        begin
                            centre_x[well_index] = x_coord;
                            centre_y[well_index] = y_coord;
                        end
                    end
                    MODE_PIXEL:
                    begin
                        r2 = int'(radius_q) * int'(radius_q);
                        for (int w = 0; w < WELLS; w++)
                        begin
                            dx = int'(x_coord) - int'(centre_x[w]);
                            dy = int'(y_coord) - int'(centre_y[w]);
                            if (dx * dx + dy * dy < r2)
                            begin
                                acc = {1'b0, well_total[w]} + pixel_value;
                                well_total[w] = acc[SUM_BITS] ? SUM_MAX : acc[SUM_BITS-1:0];
                            end
                        end
                    end
                    MODE_READ:
                    begin
                        want.well = well_index;
                        want.sum  = (well_index < WELLS) ? well_total[well_index] : '0;
                        expected_reads.push_back(want);
                    end
                    default: ;
                endcase
            end

            if (cfg_wr_en)
                radius_q = cfg_wr_data;

            outstanding <= expected_reads.size();
            errors      <= mismatch_count;
        end
    end

endmodule

// ===== tb/circular_well_pixel_summer_tb.sv =====
`timescale 1ns / 1ps
// Top of the circular well pixel summer testbench: clock, reset, stimulus and verdict.
// Depends on cwps_pkg, the block under test and cwps_checker.

module circular_well_pixel_summer_tb;
    import cwps_pkg::*;

    // quiet time before a radius write and at the end; a pixel word holds the
    // back end for a sweep of all wells and up to three words can sit in the block
    localparam int SETTLE      = 4 * (WELLS + 4);
    // cycles with no handshake or radius write before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 185;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [RADIUS_BITS-1:0] cfg_wr_data  = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    logic [MODE_BITS-1:0]   mode         = MODE_CLEAR;
    logic [INDEX_BITS-1:0]  well_index   = '0;
    logic [COORD_BITS-1:0]  x_coord      = '0;
    logic [COORD_BITS-1:0]  y_coord      = '0;
    logic [PIXEL_BITS-1:0]  pixel_value  = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [INDEX_BITS-1:0]  read_well;
    logic [SUM_BITS-1:0]    well_sum;

    int outstanding;
    int errors;

    // idle rates in percent, set at the start of each phase and cleared before the final wait
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    // where the centres were put, so pixels can be aimed at them
    int aim_x [WELLS];
    int aim_y [WELLS];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    circular_well_pixel_summer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .well_index   (well_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_well    (read_well),
        .well_sum     (well_sum)
    );

    cwps_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .well_index   (well_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_well    (read_well),
        .well_sum     (well_sum),
        .outstanding  (outstanding),
        .errors       (errors)
    );

    // result side back-pressure, redrawn every falling edge
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    // hang detector: any handshake or register write resets the count
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one input word and hold it until taken. Called and returns on a
    // falling edge; valid stays high into the next word unless a gap is drawn.
    task automatic send_word(input logic [MODE_BITS-1:0] m, input int idx, input int x,
                             input int y, input int pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        mode        <= m;
        well_index  <= INDEX_BITS'(idx);
        x_coord     <= COORD_BITS'(x);
        y_coord     <= COORD_BITS'(y);
        pixel_value <= PIXEL_BITS'(pix);
        if (m == MODE_LOAD && idx < WELLS)
        begin
            aim_x[idx] = x;
            aim_y[idx] = y;
        end
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid, let every expected read come back, then give the back end
    // time to finish pixel words that produce nothing.
    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // only called while quiet
    task automatic write_radius(input int r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= RADIUS_BITS'(r);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // a coordinate within +/- span of c, clipped to the image
    function automatic int aim_near(input int c, input int span);
        int v;
        v = c + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    initial
    begin : stimulus
        int radii [PHASES];
        int rad;
        int pick;
        int words;
        int idx;
        int base_x;
        int base_y;
        int pix;

        for (int w = 0; w < WELLS; w++)
        begin
            aim_x[w] = 0;
            aim_y[w] = 0;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, reset radius 16, every centre still at the origin
        send_word(MODE_READ, 0, 0, 0, 0);           // fresh sum is zero
        send_word(MODE_READ, 127, 0, 0, 0);         // index past the table
        send_word(MODE_LOAD, 0, 0, 0, 0);
        send_word(MODE_LOAD, 95, COORD_MAX, COORD_MAX, 0);
        send_word(MODE_LOAD, 127, 100, 100, 0);     // dropped, past the table
        send_word(MODE_LOAD, 96, 200, 200, 0);      // dropped, first index past it
        send_word(MODE_PIXEL, 0, 0, 0, 16'hFFFF);   // hits all origin wells
        send_word(MODE_PIXEL, 0, COORD_MAX, COORD_MAX, 16'hFFFF);
        send_word(MODE_PIXEL, 0, COORD_MAX, COORD_MAX, 0);
        send_word(MODE_PIXEL, 0, 15, 0, 1);         // 225 < 256: inside
        send_word(MODE_PIXEL, 0, 16, 0, 2);         // exactly on the rim: outside
        send_word(MODE_PIXEL, 0, 11, 11, 3);        // 242: inside
        send_word(MODE_PIXEL, 0, 12, 12, 4);        // 288: outside
        send_word(MODE_PIXEL, 0, COORD_MAX - 15, COORD_MAX, 5);
        send_word(MODE_READ, 0, 0, 0, 0);
        send_word(MODE_READ, 95, 0, 0, 0);
        send_word(MODE_READ, 50, 0, 0, 0);
        send_word(MODE_READ, 96, 0, 0, 0);
        send_word(MODE_CLEAR, 0, 0, 0, 0);          // sums go, centres stay
        send_word(MODE_READ, 0, 0, 0, 0);
        send_word(MODE_LOAD, 1, 2048, 2048, 0);
        send_word(MODE_PIXEL, 0, 2048, 2048, 16'hAAAA);
        send_word(MODE_PIXEL, 0, 2048, 2048, 16'h5555);
        send_word(MODE_READ, 1, 0, 0, 0);
        send_word(MODE_READ, 95, 0, 0, 0);

        // ---- random part: radius extremes and zero first, then mixed sizes
        radii[0] = 255;
        radii[1] = 1;
        radii[2] = 0;
        radii[3] = 16;
        for (int p = 4; p < PHASES; p++)
            radii[p] = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40, 2);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_quiet();
            rad = radii[p];
            write_radius(rad);

            // idle pattern cycles: none, sender, receiver, both
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase

            // wells of a phase crowd around one spot, often an image corner,
            // so that disks overlap and reach the edges
            case ($urandom_range(2))
                0: begin base_x = 0;         base_y = 0;         end
                1: begin base_x = COORD_MAX; base_y = COORD_MAX; end
                default: begin base_x = $urandom_range(COORD_MAX); base_y = $urandom_range(COORD_MAX); end
            endcase

            words = 0;
            while (words < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    // noise: any field value at all
                    send_word(MODE_BITS'($urandom_range(3)), $urandom_range(127),
                              $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                              $urandom_range(16'hFFFF));
                    words++;
                end
                else if (pick < 11)
                begin
                    send_word(MODE_CLEAR, $urandom_range(127), 0, 0, 0);
                    words++;
                end
                else if (pick < 25)
                begin
                    idx = ($urandom_range(9) == 0) ? $urandom_range(127, WELLS)
                                                   : $urandom_range(WELLS - 1);
                    send_word(MODE_LOAD, idx, aim_near(base_x, 2 * rad + 8),
                              aim_near(base_y, 2 * rad + 8), $urandom_range(16'hFFFF));
                    if (idx < WELLS)
                        words++;
                end
                else if (pick < 72)
                begin
                    // pixel aimed at a known centre, landing in and around its disk
                    idx = $urandom_range(WELLS - 1);
                    case ($urandom_range(19))
                        0: pix = 16'hFFFF;
                        1: pix = 0;
                        default: pix = $urandom_range(16'hFFFF);
                    endcase
                    send_word(MODE_PIXEL, $urandom_range(127), aim_near(aim_x[idx], rad + 2),
                              aim_near(aim_y[idx], rad + 2), pix);
                    words++;
                end
                else
                begin
                    idx = ($urandom_range(19) == 0) ? $urandom_range(127, WELLS)
                                                    : $urandom_range(WELLS - 1);
                    send_word(MODE_READ, idx, $urandom_range(COORD_MAX),
                              $urandom_range(COORD_MAX), $urandom_range(16'hFFFF));
                    words++;
                end
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_quiet();

        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== circular_well_pixel_summer.f =====
rtl/cwps_pkg.sv
rtl/cwps_ram.sv
rtl/cwps_front.sv
rtl/cwps_back.sv
rtl/circular_well_pixel_summer.sv
tb/cwps_checker.sv
tb/circular_well_pixel_summer_tb.sv
